FILE: rtl/core/sbc_pkg.sv
// Shared constants and types of the matrix balancing unit.
// Used by sbc_div, sbc_mul and the top level in rtl/core; depends on nothing.
package sbc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_PASSES = 32;
  localparam int FRAC_BITS  = 32;

  localparam int FIX_W  = 48;
  localparam int IN_FRAC = 16;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int PASS_W = $clog2(MAX_PASSES);
  localparam int MAT_AW = ROW_W + COL_W;
  localparam int RF_AW  = PASS_W + ROW_W;
  localparam int CF_AW  = PASS_W + COL_W;
  localparam int POS_W  = MAT_AW + 1;
  localparam int DIM_W  = 7;
  localparam int CNT_W  = 6;
  localparam int SUM_W  = FIX_W + ((ROW_W > COL_W) ? ROW_W : COL_W);
  localparam int DIV_W  = 2 * FRAC_BITS + 1;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam int CHUNK_W = 16;
  localparam int N_CHUNK = FIX_W / CHUNK_W;
  localparam int PROD_W = 2 * FIX_W;

  localparam logic [FIX_W-1:0] FIX_MAX = '1;
  localparam logic [FIX_W-1:0] FIX_ONE =
    {{(FIX_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  typedef enum logic [2:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_PASSES = 3'd2,
    REG_START  = 3'd3,
    REG_EVERY  = 3'd4,
    REG_EPS    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/core/sbc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sbc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of the unit.
// Depends on sbc_pkg.
module sbc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  sbc_pkg::div_ctl_t               ctl,
  input  logic [sbc_pkg::DIV_W-1:0]       num,
  input  logic [sbc_pkg::SUM_W-1:0]       den,
  output sbc_pkg::unit_stat_t             stat,
  output logic [sbc_pkg::DIV_W-1:0]       quot,
  output logic [sbc_pkg::SUM_W-1:0]       rem
);

  logic [sbc_pkg::DIV_W-1:0]  n;
  logic [sbc_pkg::SUM_W-1:0]  d;
  logic [sbc_pkg::STEP_W-1:0] cnt;
  logic [sbc_pkg::SUM_W:0]    rem_sh;
  logic                       fits;

  assign rem_sh = {rem, n[sbc_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (ctl.start) begin
        stat.busy <= 1'b1;
        cnt       <= ctl.steps;
        n         <= num;
        d         <= den;
        rem       <= '0;
        quot      <= '0;
      end else if (stat.busy) begin
        n    <= {n[sbc_pkg::DIV_W-2:0], 1'b0};
        rem  <= fits ? sbc_pkg::SUM_W'(rem_sh - {1'b0, d}) : rem_sh[sbc_pkg::SUM_W-1:0];
        quot <= {quot[sbc_pkg::DIV_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == sbc_pkg::STEP_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/sbc_mul.sv
// Fixed-point multiplier: 48 by 16 bit partial products accumulated in turn, then
// a shift by the fraction width with saturation. Depends on sbc_pkg.
module sbc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbc_pkg::FIX_W-1:0]   a,
  input  logic [sbc_pkg::FIX_W-1:0]   b,
  output sbc_pkg::unit_stat_t         stat,
  output logic [sbc_pkg::FIX_W-1:0]   res
);

  localparam int SW = $clog2(sbc_pkg::N_CHUNK + 1);

  logic [sbc_pkg::FIX_W-1:0]           ar;
  logic [sbc_pkg::FIX_W-1:0]           br;
  logic [SW-1:0]                       step;
  logic [SW-1:0]                       sh;
  logic [sbc_pkg::FIX_W+sbc_pkg::CHUNK_W-1:0] prod;
  logic [sbc_pkg::PROD_W-1:0]          acc;
  logic [sbc_pkg::CHUNK_W-1:0]         chunk;

  assign chunk = sbc_pkg::CHUNK_W'(br >> (sbc_pkg::CHUNK_W * step));
  assign sh    = step - 1'b1;
  assign res   = (acc[sbc_pkg::PROD_W-1:sbc_pkg::FRAC_BITS+sbc_pkg::FIX_W] != '0)
                 ? sbc_pkg::FIX_MAX : acc[sbc_pkg::FRAC_BITS +: sbc_pkg::FIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      step <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        ar        <= a;
        br        <= b;
        acc       <= '0;
        step      <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (step < SW'(sbc_pkg::N_CHUNK)) begin
          prod <= ar * chunk;
        end
        if (step != '0) begin
          acc <= acc + (sbc_pkg::PROD_W'(prod) << (sbc_pkg::CHUNK_W * sh));
        end
        step <= step + 1'b1;
        if (step == SW'(sbc_pkg::N_CHUNK)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/sinkhorn_balance_with_convergence_unit.sv
// Top level of the Sinkhorn-Knopp balancing unit: stream ports, APB registers, sequencer.
// Depends on sbc_pkg, sbc_ram, sbc_div and sbc_mul.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata, s_tuser, s_tlast
// m_*       out        m_tvalid/m_tready  m_tdata
// apb       in/out     psel/penable       paddr, pwdata, prdata
//
// A read request passes through S_RDOUT; an in-range load request waits in S_LDIV for
// the divider that splits the load position into row and column. The last element starts
// a balancing run that uses the shared divider for the target and every reciprocal and
// the multiplier for every element. Reset is synchronous and needs no clearing pass.
// The input is not ready while a request is in work or a result waits.
module sinkhorn_balance_with_convergence_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // value[31:0], read_pass[36:32], read_index[42:37]
  input  logic [1:0]  s_tuser,   // operation[0], read_kind[1]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // factor[47:0], pass_count[53:48], converged[54],
                                 // finished[55], zero_sum[56], out_of_range[57]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LDIV   = 11'b00000000010,
    S_RDOUT  = 11'b00000000100,
    S_TGT    = 11'b00000001000,
    S_SUMRD  = 11'b00000010000,
    S_SUMACC = 11'b00000100000,
    S_RECIP  = 11'b00001000000,
    S_MRD    = 11'b00010000000,
    S_MMUL   = 11'b00100000000,
    S_MWAIT  = 11'b01000000000,
    S_PEND   = 11'b10000000000
  } state_t;

  localparam int DIM_W = sbc_pkg::DIM_W;
  localparam int CNT_W = sbc_pkg::CNT_W;
  localparam int FIX_W = sbc_pkg::FIX_W;

  state_t state;

  logic [DIM_W-1:0] rows_used, cols_used;
  logic [CNT_W-1:0] max_passes, check_start, check_every;
  logic [FIX_W-1:0] epsilon;

  logic [DIM_W-1:0] nr, nc, nr_b, nc_b, o, j, nouter, ninner, o_inc, j_inc;
  logic [CNT_W-1:0] np, every, pass, p_inc, sched_cnt, passes_written, fpc, avail;
  logic [sbc_pkg::POS_W-1:0] pos;
  logic [2*DIM_W-1:0] area;
  logic in_range, acc, wr_en, col_phase, all_close, zero, st_conv, st_zero;
  logic active, sched, bal_start, stored_ok, oor_r, ofinished, last_r, kind_r;
  logic [31:0] value_r;
  logic [sbc_pkg::SUM_W-1:0] sum, sum_next;
  logic [FIX_W-1:0] fac, target, ofactor, recip, diff;
  logic [DIM_W-1:0] er, ec;

  logic [sbc_pkg::MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [FIX_W-1:0] mat_wdata, mat_q, row_q, col_q;
  logic mat_we, rf_we, cf_we;
  logic [sbc_pkg::RF_AW-1:0] rf_waddr, rf_raddr;
  logic [sbc_pkg::CF_AW-1:0] cf_waddr, cf_raddr;

  sbc_pkg::div_ctl_t   div_ctl;
  sbc_pkg::unit_stat_t div_stat, mul_stat;
  logic [sbc_pkg::DIV_W-1:0] div_num, div_quot;
  logic [sbc_pkg::SUM_W-1:0] div_den, div_rem;
  logic [FIX_W-1:0] mul_res;
  logic mul_start;

  logic        in_op, in_kind;
  logic [31:0] in_value;
  logic [4:0]  in_pass;
  logic [5:0]  in_idx;

  assign in_op    = s_tuser[0];
  assign in_kind  = s_tuser[1];
  assign in_value = s_tdata[31:0];
  assign in_pass  = s_tdata[36:32];
  assign in_idx   = s_tdata[42:37];

  assign nr = (rows_used == '0) ? DIM_W'(1) :
              (rows_used > DIM_W'(sbc_pkg::MAX_ROWS)) ? DIM_W'(sbc_pkg::MAX_ROWS) : rows_used;
  assign nc = (cols_used == '0) ? DIM_W'(1) :
              (cols_used > DIM_W'(sbc_pkg::MAX_COLS)) ? DIM_W'(sbc_pkg::MAX_COLS) : cols_used;
  assign np = (max_passes > CNT_W'(sbc_pkg::MAX_PASSES)) ? CNT_W'(sbc_pkg::MAX_PASSES)
                                                          : max_passes;
  assign every = (check_every == '0) ? CNT_W'(1) : check_every;
  assign area  = (2*DIM_W)'(nr) * (2*DIM_W)'(nc);
  assign in_range = (2*DIM_W)'(pos) < area;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign acc      = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;

  assign nouter = col_phase ? nc_b : nr_b;
  assign ninner = col_phase ? nr_b : nc_b;
  assign o_inc  = o + 1'b1;
  assign j_inc  = j + 1'b1;
  assign p_inc  = pass + 1'b1;
  assign er     = col_phase ? j : o;
  assign ec     = col_phase ? o : j;
  assign sum_next = sum + sbc_pkg::SUM_W'(mat_q);
  assign recip  = (div_quot[sbc_pkg::DIV_W-1:FIX_W] != '0) ? sbc_pkg::FIX_MAX
                                                          : div_quot[FIX_W-1:0];
  assign diff   = (recip > target) ? recip - target : target - recip;
  assign active = p_inc >= check_start;
  assign sched  = active && (sched_cnt == '0);
  assign avail  = (fpc == '0) ? CNT_W'(1) :
                  (fpc > CNT_W'(sbc_pkg::MAX_PASSES)) ? CNT_W'(sbc_pkg::MAX_PASSES) : fpc;

  assign bal_start = (acc && in_op == sbc_pkg::OP_LOAD && !in_range && s_tlast) ||
                     (state == S_LDIV && div_stat.done && last_r);

  always_comb begin
    div_ctl = '0;
    div_num = '0;
    div_den = '0;
    if (acc && in_op == sbc_pkg::OP_LOAD && in_range) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = sbc_pkg::STEP_W'(sbc_pkg::POS_W);
      div_num = sbc_pkg::DIV_W'(pos) << (sbc_pkg::DIV_W - sbc_pkg::POS_W);
      div_den = sbc_pkg::SUM_W'(nc);
    end else if (bal_start) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = sbc_pkg::STEP_W'(DIM_W + sbc_pkg::FRAC_BITS);
      div_num = sbc_pkg::DIV_W'(nc) << (sbc_pkg::DIV_W - DIM_W);
      div_den = sbc_pkg::SUM_W'(nr);
    end else if (state == S_SUMACC && j_inc == ninner) begin
      div_ctl.start = 1'b1;
      div_ctl.steps = sbc_pkg::STEP_W'(sbc_pkg::DIV_W);
      div_num = sbc_pkg::DIV_W'(1) << (sbc_pkg::DIV_W - 1);
      div_den = sum_next;
    end
  end

  assign mul_start = (state == S_MMUL);
  assign mat_raddr = {er[sbc_pkg::ROW_W-1:0], ec[sbc_pkg::COL_W-1:0]};
  assign mat_we    = (state == S_LDIV && div_stat.done) || (state == S_MWAIT && mul_stat.done);
  assign mat_waddr = (state == S_LDIV)
                     ? {div_quot[sbc_pkg::ROW_W-1:0], div_rem[sbc_pkg::COL_W-1:0]} : mat_raddr;
  assign mat_wdata = (state == S_LDIV)
                     ? FIX_W'(value_r) << (sbc_pkg::FRAC_BITS - sbc_pkg::IN_FRAC) : mul_res;

  assign rf_we    = (state == S_RECIP) && div_stat.done && !col_phase;
  assign cf_we    = (state == S_RECIP) && div_stat.done && col_phase;
  assign rf_waddr = {pass[sbc_pkg::PASS_W-1:0], o[sbc_pkg::ROW_W-1:0]};
  assign cf_waddr = {pass[sbc_pkg::PASS_W-1:0], o[sbc_pkg::COL_W-1:0]};
  assign rf_raddr = {in_pass[sbc_pkg::PASS_W-1:0], in_idx[sbc_pkg::ROW_W-1:0]};
  assign cf_raddr = {in_pass[sbc_pkg::PASS_W-1:0], in_idx[sbc_pkg::COL_W-1:0]};

  sbc_ram #(.WIDTH(FIX_W), .DEPTH(sbc_pkg::MAX_ROWS * sbc_pkg::MAX_COLS)) u_mat (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_q)
  );

  sbc_ram #(.WIDTH(FIX_W), .DEPTH(sbc_pkg::MAX_PASSES * sbc_pkg::MAX_ROWS)) u_rowf (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(recip), .raddr(rf_raddr), .rdata(row_q)
  );

  sbc_ram #(.WIDTH(FIX_W), .DEPTH(sbc_pkg::MAX_PASSES * sbc_pkg::MAX_COLS)) u_colf (
    .clk, .we(cf_we), .waddr(cf_waddr), .wdata(recip), .raddr(cf_raddr), .rdata(col_q)
  );

  sbc_div u_div (
    .clk, .rst, .ctl(div_ctl), .num(div_num), .den(div_den),
    .stat(div_stat), .quot(div_quot), .rem(div_rem)
  );

  sbc_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mat_q), .b(fac), .stat(mul_stat), .res(mul_res)
  );

  always_comb begin
    prdata = '0;
    unique case (paddr[5:3])
      sbc_pkg::REG_ROWS:   prdata = 64'(rows_used);
      sbc_pkg::REG_COLS:   prdata = 64'(cols_used);
      sbc_pkg::REG_PASSES: prdata = 64'(max_passes);
      sbc_pkg::REG_START:  prdata = 64'(check_start);
      sbc_pkg::REG_EVERY:  prdata = 64'(check_every);
      sbc_pkg::REG_EPS:    prdata = 64'(epsilon);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used   <= DIM_W'(64);
      cols_used   <= DIM_W'(64);
      max_passes  <= CNT_W'(32);
      check_start <= CNT_W'(1);
      check_every <= CNT_W'(1);
      epsilon     <= FIX_W'(4295);
    end else if (wr_en) begin
      unique case (paddr[5:3])
        sbc_pkg::REG_ROWS:   rows_used   <= pwdata[DIM_W-1:0];
        sbc_pkg::REG_COLS:   cols_used   <= pwdata[DIM_W-1:0];
        sbc_pkg::REG_PASSES: max_passes  <= pwdata[CNT_W-1:0];
        sbc_pkg::REG_START:  check_start <= pwdata[CNT_W-1:0];
        sbc_pkg::REG_EVERY:  check_every <= pwdata[CNT_W-1:0];
        sbc_pkg::REG_EPS:    epsilon     <= pwdata[FIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      pos            <= '0;
      passes_written <= '0;
      fpc            <= '0;
      st_conv        <= 1'b0;
      st_zero        <= 1'b0;
      nr_b           <= '0;
      nc_b           <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (bal_start) begin
        state          <= S_TGT;
        nr_b           <= nr;
        nc_b           <= nc;
        passes_written <= '0;
        zero           <= 1'b0;
        pass           <= '0;
        sched_cnt      <= (check_start == '0) ? every - 1'b1 : '0;
        col_phase      <= 1'b0;
        o              <= '0;
        j              <= '0;
        sum            <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            value_r   <= in_value;
            last_r    <= s_tlast;
            kind_r    <= in_kind;
            ofactor   <= '0;
            ofinished <= 1'b0;
            oor_r     <= 1'b0;
            if (in_op == sbc_pkg::OP_READ) begin
              state     <= S_RDOUT;
              oor_r     <= (CNT_W'(in_pass) >= avail) ||
                           (DIM_W'(in_idx) >= (in_kind ? nc : nr));
              stored_ok <= (CNT_W'(in_pass) < passes_written) &&
                           (DIM_W'(in_idx) < (in_kind ? nc_b : nr_b));
            end else if (in_range) begin
              state <= S_LDIV;
            end else if (!s_tlast) begin
              m_tvalid <= 1'b1;
            end
          end
        end
        S_LDIV: begin
          if (div_stat.done) begin
            pos <= pos + 1'b1;
            if (!last_r) begin
              state    <= S_IDLE;
              m_tvalid <= 1'b1;
            end
          end
        end
        S_RDOUT: begin
          state    <= S_IDLE;
          m_tvalid <= 1'b1;
          if (!oor_r) begin
            ofactor <= stored_ok ? (kind_r ? col_q : row_q) : sbc_pkg::FIX_ONE;
          end
        end
        S_TGT: begin
          if (div_stat.done) begin
            target <= recip;
            if (np == '0) begin
              state     <= S_IDLE;
              fpc       <= '0;
              st_conv   <= 1'b0;
              st_zero   <= 1'b0;
              pos       <= '0;
              ofinished <= 1'b1;
              m_tvalid  <= 1'b1;
            end else begin
              state <= S_SUMRD;
            end
          end
        end
        S_SUMRD: begin
          state <= S_SUMACC;
        end
        S_SUMACC: begin
          sum <= sum_next;
          j   <= j_inc;
          state <= (j_inc == ninner) ? S_RECIP : S_SUMRD;
        end
        S_RECIP: begin
          if (div_stat.done) begin
            fac <= recip;
            j   <= '0;
            if (sum == '0) begin
              zero <= 1'b1;
            end
            if (col_phase && diff > epsilon) begin
              all_close <= 1'b0;
            end
            state <= S_MRD;
          end
        end
        S_MRD: begin
          state <= S_MMUL;
        end
        S_MMUL: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_stat.done) begin
            j <= j_inc;
            state <= S_MRD;
            if (j_inc == ninner) begin
              o     <= o_inc;
              j     <= '0;
              sum   <= '0;
              state <= S_SUMRD;
              if (o_inc == nouter) begin
                o <= '0;
                if (col_phase) begin
                  state <= S_PEND;
                end else begin
                  col_phase <= 1'b1;
                  all_close <= 1'b1;
                end
              end
            end
          end
        end
        S_PEND: begin
          passes_written <= p_inc;
          if (active) begin
            sched_cnt <= sched ? every - 1'b1 : sched_cnt - 1'b1;
          end
          if ((sched && all_close) || p_inc == np) begin
            state     <= S_IDLE;
            fpc       <= (sched && all_close) ? pass : np;
            st_conv   <= sched && all_close;
            st_zero   <= zero;
            pos       <= '0;
            ofinished <= 1'b1;
            m_tvalid  <= 1'b1;
          end else begin
            pass      <= p_inc;
            col_phase <= 1'b0;
            o         <= '0;
            j         <= '0;
            sum       <= '0;
            state     <= S_SUMRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, oor_r, st_zero, ofinished, st_conv, fpc, ofactor};

endmodule

FILE: rtl/core/sbc_checker.sv
// Port-level checks of the balancing unit, bound to its top level.
// Depends on sinkhorn_balance_with_convergence_unit.
module sbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while a result waits");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[57] |-> m_tdata[47:0] == 48'd0)
    else $error("out of range read returned a factor");

  a_finish_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[55] |-> !m_tdata[57] && m_tdata[47:0] == 48'd0)
    else $error("finished result carries read data");

endmodule

bind sinkhorn_balance_with_convergence_unit sbc_checker u_sbc_checker (.*);

FILE: dv/sinkhorn_balance_with_convergence_unit_tb.sv
// Testbench of the Sinkhorn-Knopp balancing unit: stream requests, APB registers, checking.
// A scoreboard class predicts each result from its own copy of the matrix and factor stores.
// Depends on sbc_pkg and the unit sinkhorn_balance_with_convergence_unit.
module sinkhorn_balance_with_convergence_unit_tb;
  import sbc_pkg::*;

  typedef struct {
    logic [47:0] factor;
    logic [5:0]  pass_count;
    logic        converged;
    logic        finished;
    logic        zero_sum;
    logic        out_of_range;
  } balance_result_t;

  class balance_scoreboard;
    logic [47:0] matrix[MAX_ROWS*MAX_COLS];
    logic [47:0] row_factor[MAX_PASSES*MAX_ROWS];
    logic [47:0] col_factor[MAX_PASSES*MAX_COLS];
    int unsigned load_pos;
    logic [5:0] final_count;
    logic conv_flag, zero_flag;
    logic [6:0] rows_reg, cols_reg;
    logic [5:0] passes_reg, start_reg, every_reg;
    logic [47:0] eps_reg;
    balance_result_t expected_q[$];
    int mismatches, loads, reads, runs, conv_runs;

    function new();
      for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) matrix[i] = '0;
      refill_ones();
      load_pos = 0;
      final_count = 0;
      conv_flag = 0;
      zero_flag = 0;
      rows_reg = 64;
      cols_reg = 64;
      passes_reg = 32;
      start_reg = 1;
      every_reg = 1;
      eps_reg = 48'd4295;
    endfunction

    function void refill_ones();
      for (int i = 0; i < MAX_PASSES*MAX_ROWS; i++) row_factor[i] = FIX_ONE;
      for (int i = 0; i < MAX_PASSES*MAX_COLS; i++) col_factor[i] = FIX_ONE;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] val);
      case (idx)
        REG_ROWS:   rows_reg = val[6:0];
        REG_COLS:   cols_reg = val[6:0];
        REG_PASSES: passes_reg = val[5:0];
        REG_START:  start_reg = val[5:0];
        REG_EVERY:  every_reg = val[5:0];
        REG_EPS:    eps_reg = val[47:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_rows();
      return rows_reg == 0 ? 1 : (rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg);
    endfunction

    function int unsigned used_cols();
      return cols_reg == 0 ? 1 : (cols_reg > MAX_COLS ? MAX_COLS : cols_reg);
    endfunction

    function logic [47:0] scale(logic [47:0] a, logic [47:0] b);
      logic [95:0] p;
      p = {48'd0, a} * {48'd0, b};
      p = p >> FRAC_BITS;
      return (p > {48'd0, FIX_MAX}) ? FIX_MAX : p[47:0];
    endfunction

    function logic [47:0] reciprocal(logic [63:0] s);
      logic [127:0] q;
      if (s == 0) begin
        zero_flag = 1;
        return FIX_MAX;
      end
      q = (128'd1 << (2*FRAC_BITS)) / {64'd0, s};
      return (q > {80'd0, FIX_MAX}) ? FIX_MAX : q[47:0];
    endfunction

    function void balance();
      int unsigned nr, nc, np, every, count, idx;
      logic [63:0] target, s, d;
      logic [47:0] f;
      bit all_close;
      nr = used_rows();
      nc = used_cols();
      np = passes_reg > MAX_PASSES ? MAX_PASSES : passes_reg;
      every = every_reg == 0 ? 1 : every_reg;
      target = (64'(nc) << FRAC_BITS) / nr;
      if (target > {16'd0, FIX_MAX}) target = {16'd0, FIX_MAX};
      count = np;
      zero_flag = 0;
      conv_flag = 0;
      refill_ones();
      for (int i = 0; i < np; i++) begin
        all_close = 1;
        for (int r = 0; r < nr; r++) begin
          s = 0;
          for (int c = 0; c < nc; c++) s += matrix[r*MAX_COLS+c];
          f = reciprocal(s);
          row_factor[i*MAX_ROWS+r] = f;
          for (int c = 0; c < nc; c++) begin
            idx = r*MAX_COLS+c;
            matrix[idx] = scale(matrix[idx], f);
          end
        end
        for (int c = 0; c < nc; c++) begin
          s = 0;
          for (int r = 0; r < nr; r++) s += matrix[r*MAX_COLS+c];
          f = reciprocal(s);
          col_factor[i*MAX_COLS+c] = f;
          for (int r = 0; r < nr; r++) begin
            idx = r*MAX_COLS+c;
            matrix[idx] = scale(matrix[idx], f);
          end
          d = (f > target) ? f - target : target - f;
          if (d > eps_reg) all_close = 0;
        end
        if (i + 1 >= start_reg && ((i + 1 - start_reg) % every) == 0 && all_close) begin
          conv_flag = 1;
          count = i;
          break;
        end
      end
      final_count = count[5:0];
      runs++;
      if (conv_flag) conv_runs++;
    endfunction

    function void note_request(logic op, logic [31:0] value, logic last, logic kind,
                               logic [4:0] rpass, logic [5:0] ridx);
      balance_result_t e;
      int unsigned nr, nc, avail, lim;
      logic [47:0] v;
      nr = used_rows();
      nc = used_cols();
      e.factor = '0;
      e.out_of_range = 0;
      e.finished = 0;
      if (op == OP_LOAD) begin
        loads++;
        if (load_pos < nr*nc) begin
          v = {16'd0, value} << (FRAC_BITS - IN_FRAC);
          matrix[(load_pos / nc)*MAX_COLS + (load_pos % nc)] = v;
          load_pos++;
        end
        if (last) begin
          balance();
          load_pos = 0;
          e.finished = 1;
        end
      end else begin
        reads++;
        avail = final_count == 0 ? 1 : final_count;
        if (avail > MAX_PASSES) avail = MAX_PASSES;
        lim = (kind == KIND_COL) ? nc : nr;
        if (rpass >= avail || ridx >= lim) e.out_of_range = 1;
        else if (kind == KIND_COL) e.factor = col_factor[rpass*MAX_COLS + ridx];
        else e.factor = row_factor[rpass*MAX_ROWS + ridx];
      end
      e.pass_count = final_count;
      e.converged = conv_flag;
      e.zero_sum = zero_flag;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [63:0] data);
      balance_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result with no request pending: %h", data);
        return;
      end
      e = expected_q.pop_front();
      if (data[47:0] !== e.factor || data[53:48] !== e.pass_count || data[54] !== e.converged
          || data[55] !== e.finished || data[56] !== e.zero_sum
          || data[57] !== e.out_of_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected factor %h count %0d conv %b fin %b zero %b oor %b, got %h",
                   e.factor, e.pass_count, e.converged, e.finished, e.zero_sum,
                   e.out_of_range, data);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [47:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0;
  logic [63:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;

  balance_scoreboard board;
  bit no_gaps = 0;
  bit hold_request = 0;
  int sent = 0;

  sinkhorn_balance_with_convergence_unit DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("sinkhorn_balance_with_convergence_unit verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    int hold_left;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = 300;
      m_tready <= 0;
    end else begin
      m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
    if (!rst && m_tvalid && m_tready && board != null) board.check_result(m_tdata);
  end

  task automatic send(logic op, logic [31:0] value, logic last, logic kind,
                      logic [4:0] rpass, logic [5:0] ridx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, ridx, rpass, value};
    s_tuser <= {kind, op};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    board.note_request(op, value, last, kind, rpass, ridx);
    sent++;
  endtask

  task automatic apb_write(reg_idx_t idx, logic [63:0] val);
    s_tvalid <= 0;
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic configure(logic [6:0] nr, logic [6:0] nc, logic [5:0] np,
                           logic [5:0] cs, logic [5:0] ce, logic [47:0] eps);
    drain();
    apb_write(REG_ROWS, nr);
    apb_write(REG_COLS, nc);
    apb_write(REG_PASSES, np);
    apb_write(REG_START, cs);
    apb_write(REG_EVERY, ce);
    apb_write(REG_EPS, eps);
  endtask

  function automatic logic [31:0] pick_value(int style);
    case (style)
      0: return 32'h0001_0000;
      1: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(1, 32'h0004_0000);
      default: return $urandom_range(0, 9) == 0 ? 32'd0 : $urandom();
    endcase
  endfunction

  // Loads n elements (style picks the value mix); the last one carries tlast.
  task automatic load_matrix(int n, int style, bit zero_row);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      v = (zero_row && i < board.used_cols()) ? 32'd0 : pick_value(style);
      send(OP_LOAD, v, i == n - 1, $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic read_factor();
    logic [4:0] p;
    logic [5:0] x;
    logic k;
    k = $urandom();
    p = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, board.final_count);
    x = $urandom_range(0, 4) == 0 ? $urandom()
        : $urandom_range(0, (k ? board.used_cols() : board.used_rows()) - 1);
    send(OP_READ, $urandom(), $urandom(), k, p, x);
  endtask

  initial begin
    int n, nr, nc, style;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reads before any balancing return ones on pass 0 only.
    send(OP_READ, 32'hFFFF_FFFF, 1, KIND_ROW, 5'd0, 6'd63);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd0, 6'd0);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd31, 6'd63);

    // Full-size matrix writes every entry once, so early last never reads unwritten data.
    configure(7'd64, 7'd64, 6'd1, 6'd1, 6'd1, 48'hFFFF_FFFF_FFFF);
    load_matrix(64*64, 2, 1);
    send(OP_READ, 32'd0, 0, KIND_ROW, 5'd0, 6'd63);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd0, 6'd63);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd1, 6'd0);

    // Uniform matrix with zero tolerance, tested on every pass from the first.
    configure(7'd3, 7'd3, 6'd32, 6'd0, 6'd0, 48'd0);
    load_matrix(9, 0, 0);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd0, 6'd2);
    // No passes at all: pass 0 reads ones.
    configure(7'd2, 7'd2, 6'd0, 6'd63, 6'd63, 48'd0);
    load_matrix(4, 2, 0);
    send(OP_READ, 32'd0, 0, KIND_ROW, 5'd0, 6'd1);
    // Extreme size codes clamp to the limits; extra elements are dropped.
    configure(7'd127, 7'd0, 6'd2, 6'd1, 6'd1, 48'd4295);
    load_matrix(64 + 3, 1, 0);
    configure(7'd0, 7'd127, 6'd63, 6'd40, 6'd1, 48'd4295);
    load_matrix(30, 2, 0);
    send(OP_READ, 32'd0, 0, KIND_COL, 5'd0, 6'd63);

    while (sent < 4096 + 1300) begin
      no_gaps = $urandom_range(0, 4) == 0;
      if ($urandom_range(0, 3) != 0) begin
        nr = $urandom_range(1, 4);
        nc = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) begin
          nr = $urandom_range(5, 8);
          nc = $urandom_range(5, 8);
        end
        configure(nr, nc,
                  $urandom_range(0, 11) == 0 ? 6'd32 : $urandom_range(0, 6),
                  $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 4),
                  $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 3),
                  $urandom_range(0, 3) == 0 ? 48'hFFFF_FFFF_FFFF
                    : ($urandom_range(0, 2) == 0 ? {$urandom(), $urandom()} >> 16
                       : 48'($urandom_range(0, 1 << 26))));
      end
      n = board.used_rows() * board.used_cols();
      style = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
        0: n = $urandom_range(1, n);
        1: n = n + $urandom_range(1, 3);
        default: ;
      endcase
      load_matrix(n, style, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        no_gaps = 1;
        hold_request = 1;
        repeat (60) read_factor();
      end else begin
        repeat ($urandom_range(5, 30)) read_factor();
      end
    end

    drain();
    $display("Covered %0d loads, %0d factor reads, %0d balancing runs (%0d converged).",
             board.loads, board.reads, board.runs, board.conv_runs);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("sinkhorn_balance_with_convergence_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", board.mismatches,
               board.expected_q.size());
      $display("sinkhorn_balance_with_convergence_unit verification failed");
    end
    $finish;
  end
endmodule
